@@ hdl/dtfp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character codes and small helpers for the decimal text to
// fixed point converter. Depends on nothing.
package dtfp_pkg;

    localparam int OUT_W = 48;
    localparam int REM_W = 30;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [OUT_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } text_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    overflow;
    } fixed_item_t;

    function automatic logic [REM_W-1:0] pow10(input logic [3:0] n);
        logic [REM_W-1:0] p;
        case (n)
            4'd0: p = 30'd1;
            4'd1: p = 30'd10;
            4'd2: p = 30'd100;
            4'd3: p = 30'd1000;
            4'd4: p = 30'd10000;
            4'd5: p = 30'd100000;
            4'd6: p = 30'd1000000;
            4'd7: p = 30'd10000000;
            4'd8: p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

@@ hdl/decimal_text_to_fixed_point.sv @@
`timescale 1ns / 1ps
// Top level of the decimal text to fixed point converter: parser, shared
// restoring divider and output register. Depends on dtfp_pkg.
//
// The block reads a decimal number one character item at a time and returns
// it as signed fixed point with FRAC_BITS fraction bits, rounded to nearest
// with ties away from zero. An item with first set starts a new number and
// drops any unfinished one. Leading whitespace is skipped, then an optional
// sign, integer digits, an optional point and fraction digits are taken; the
// first character that cannot continue the number (NUL included) ends it and
// yields one result item. Fraction digits past MAX_FRAC_DIGITS are consumed
// and dropped. The mantissa and the result saturate, and either saturation
// sets overflow. Characters that continue a number are accepted without a stall. The
// character that ends a number starts the shared restoring divider, which
// forms one quotient bit per cycle, followed by a rounding step and a clamp
// step; no item is accepted during that time. A finished result waits in the
// output register while the next characters are accepted; only the clamp
// step of the following number waits for it to be taken.
module decimal_text_to_fixed_point
    import dtfp_pkg::*;
#(
    parameter int FRAC_BITS       = 16,
    parameter int MANT_BITS       = 40,
    parameter int MAX_FRAC_DIGITS = 9
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  text_item_t  text,
    output logic        result_valid,
    input  logic        result_ready,
    output fixed_item_t result
);

    localparam int QW    = MANT_BITS + FRAC_BITS;
    localparam int CW    = (QW + 1 > OUT_W) ? QW + 1 : OUT_W;
    localparam int CNT_W = $clog2(QW);
    localparam int MX_W  = MANT_BITS + 4;

    // Sequencer states.
    localparam logic [1:0] S_CHAR  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_ROUND = 2'd2;
    localparam logic [1:0] S_CLAMP = 2'd3;

    // Parse phases.
    localparam logic [1:0] PH_DONE = 2'd0;
    localparam logic [1:0] PH_LEAD = 2'd1;
    localparam logic [1:0] PH_INT  = 2'd2;
    localparam logic [1:0] PH_FRAC = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           phase_reg, phase_next;
    logic                 negative_reg, negative_next;
    logic [MANT_BITS-1:0] mantissa_reg, mantissa_next;
    logic [3:0]           frac_count_reg, frac_count_next;
    logic                 saturated_reg, saturated_next;
    logic [QW-1:0]        dq_reg, dq_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [REM_W-1:0]     div_reg, div_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]        mag_reg, mag_next;
    logic                 result_valid_reg, result_valid_next;
    fixed_item_t          result_reg, result_next;

    // Values seen by the current character once a start mark is applied.
    logic [1:0]           phase_eff;
    logic                 negative_eff;
    logic [MANT_BITS-1:0] mantissa_eff;
    logic [3:0]           frac_eff;
    logic                 saturated_eff;

    logic [MX_W-1:0]      m_ext;
    logic [MX_W-1:0]      m10;
    logic                 sat_hit;
    logic [MANT_BITS-1:0] m_digit;
    logic                 frac_full;
    logic                 finish;

    logic [1:0]           c_phase;
    logic                 c_negative;
    logic [MANT_BITS-1:0] c_mantissa;
    logic [3:0]           c_frac;
    logic                 c_saturated;

    logic [REM_W:0]       trial;
    logic                 trial_ge;
    logic [REM_W:0]       trial_diff;
    logic                 round_up;
    logic [CW-1:0]        limit;
    logic                 too_big;
    logic [OUT_W-1:0]     mag_clamped;

    // Character parser: the effect of one character on the parse state.
    always_comb
    begin
        phase_eff     = text.first ? PH_LEAD : phase_reg;
        negative_eff  = text.first ? 1'b0 : negative_reg;
        mantissa_eff  = text.first ? '0 : mantissa_reg;
        frac_eff      = text.first ? 4'd0 : frac_count_reg;
        saturated_eff = text.first ? 1'b0 : saturated_reg;

        m_ext   = MX_W'(mantissa_eff);
        m10     = (m_ext << 3) + (m_ext << 1) + MX_W'(text.ch - CH_ZERO);
        sat_hit = |m10[MX_W-1:MANT_BITS];
        m_digit = sat_hit ? '1 : m10[MANT_BITS-1:0];
        frac_full = (frac_eff >= 4'(MAX_FRAC_DIGITS));

        c_phase     = phase_eff;
        c_negative  = negative_eff;
        c_mantissa  = mantissa_eff;
        c_frac      = frac_eff;
        c_saturated = saturated_eff;
        finish      = 1'b0;

        case (phase_eff)
            PH_LEAD:
            begin
                if (is_blank(text.ch))
                begin
                    c_phase = PH_LEAD;
                end
                else if (text.ch == CH_MINUS || text.ch == CH_PLUS)
                begin
                    c_negative = (text.ch == CH_MINUS);
                    c_phase    = PH_INT;
                end
                else if (is_digit(text.ch))
                begin
                    c_mantissa  = m_digit;
                    c_saturated = saturated_eff | sat_hit;
                    c_phase     = PH_INT;
                end
                else if (text.ch == CH_POINT)
                begin
                    c_phase = PH_FRAC;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            PH_INT:
            begin
                if (is_digit(text.ch))
                begin
                    c_mantissa  = m_digit;
                    c_saturated = saturated_eff | sat_hit;
                end
                else if (text.ch == CH_POINT)
                begin
                    c_phase = PH_FRAC;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            PH_FRAC:
            begin
                if (is_digit(text.ch))
                begin
                    if (!frac_full)
                    begin
                        c_mantissa  = m_digit;
                        c_saturated = saturated_eff | sat_hit;
                        c_frac      = frac_eff + 4'd1;
                    end
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                c_phase = PH_DONE;
            end
        endcase

        if (finish)
        begin
            c_phase = PH_DONE;
        end
    end

    // Shared divider step, rounding and clamp arithmetic.
    always_comb
    begin
        trial       = {rem_reg, dq_reg[QW-1]};
        trial_ge    = (trial >= {1'b0, div_reg});
        trial_diff  = trial - {1'b0, div_reg};
        round_up    = ({rem_reg, 1'b0} >= {1'b0, div_reg});
        limit       = negative_reg ? CW'(NEG_LIMIT) : CW'(POS_LIMIT);
        too_big     = (mag_reg > limit);
        mag_clamped = too_big ? limit[OUT_W-1:0] : mag_reg[OUT_W-1:0];
    end

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        negative_next     = negative_reg;
        mantissa_next     = mantissa_reg;
        frac_count_next   = frac_count_reg;
        saturated_next    = saturated_reg;
        dq_next           = dq_reg;
        rem_next          = rem_reg;
        div_next          = div_reg;
        cnt_next          = cnt_reg;
        mag_next          = mag_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_CHAR:
            begin
                if (text_valid)
                begin
                    phase_next      = c_phase;
                    negative_next   = c_negative;
                    mantissa_next   = c_mantissa;
                    frac_count_next = c_frac;
                    saturated_next  = c_saturated;
                    if (finish)
                    begin
                        dq_next    = QW'(mantissa_eff) << FRAC_BITS;
                        rem_next   = '0;
                        div_next   = pow10(frac_eff);
                        cnt_next   = CNT_W'(QW - 1);
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                dq_next  = {dq_reg[QW-2:0], trial_ge};
                rem_next = trial_ge ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                mag_next   = CW'(dq_reg) + CW'(round_up);
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.value    = negative_reg ? $signed(-mag_clamped)
                                                        : $signed(mag_clamped);
                    result_next.overflow = saturated_reg | too_big;
                    result_valid_next    = 1'b1;
                    state_next           = S_CHAR;
                end
            end
            default:
            begin
                state_next = S_CHAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CHAR;
            phase_reg        <= PH_DONE;
            negative_reg     <= 1'b0;
            mantissa_reg     <= '0;
            frac_count_reg   <= 4'd0;
            saturated_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            negative_reg     <= negative_next;
            mantissa_reg     <= mantissa_next;
            frac_count_reg   <= frac_count_next;
            saturated_reg    <= saturated_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        cnt_reg    <= cnt_next;
        mag_reg    <= mag_next;
        result_reg <= result_next;
    end

    assign text_ready   = (state_reg == S_CHAR);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The kept fraction digit count never passes its limit.
    a_frac_limit: assert property (@(posedge clk) disable iff (!rst_n)
        frac_count_reg <= 4'(MAX_FRAC_DIGITS))
        else $error("fraction digit count above limit");

    // The divisor is a nonzero power of ten while the divider runs.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_reg != '0))
        else $error("zero divisor in divider");

    // Rounding follows the last divider step only.
    a_round_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> ($past(state_reg) == S_DIV && $past(cnt_reg) == '0))
        else $error("rounding entered early");

    // A new result item appears only out of the clamp cycle.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == S_CLAMP))
        else $error("result raised outside clamp");

    // A finished number always leaves the parser in the done phase.
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHAR && text_valid && finish) |=> (phase_reg == PH_DONE))
        else $error("parse not closed after end of number");

endmodule
